// ----- rtl/lkv_pkg.sv -----
// lkv_pkg: widths, operation codes and the broadcast bundle shared by the
// LRU key-value cache core and its recency-ordered storage cells.
// No dependencies.
`default_nettype none

package lkv_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// control and key broadcast from the core to every cell
	typedef struct packed {
		logic             cmp;  // compare phase: latch key match
		logic             upd;  // update phase: shift enabled cells
		logic [KEY_W-1:0] key;  // key of the item in flight
	} lkv_bcast_t;

endpackage

`default_nettype wire

// ----- rtl/lkv_cell.sv -----
// lkv_cell: one storage cell of the recency-ordered chain. Holds a valid
// bit, key and data, compares its key to the broadcast key, and takes its
// neighbor's contents when told to shift. Depends on lkv_pkg.
`default_nettype none

module lkv_cell
	import lkv_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lkv_bcast_t        bc,
	input  wire logic              shift,
	input  wire logic              prev_valid,
	input  wire logic [KEY_W-1:0]  prev_key,
	input  wire logic [DATA_W-1:0] prev_data,
	output logic                   valid,
	output logic [KEY_W-1:0]       key,
	output logic [DATA_W-1:0]      data,
	output logic                   match
);

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              match_q;

	// valid and match are control: clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (bc.cmp) begin
				match_q <= valid_q && (key_q == bc.key);
			end
			if (bc.upd && shift) begin
				valid_q <= prev_valid;
			end
		end
	end

	// take the neighbor's key and data on a shift
	always_ff @(posedge clk) begin
		if (bc.upd && shift) begin
			key_q  <= prev_key;
			data_q <= prev_data;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign data  = data_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ----- rtl/lru_key_value_cache_core.sv -----
// lru_key_value_cache_core: fully associative LRU key-value cache built as
// a chain of lkv_cell stages kept in recency order. Depends on lkv_pkg
// and lkv_cell.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  command   | start, busy        | operation, key, value
//  result    | done (one cycle)   | found, read_value, evicted, evicted_key
//  config    | cfg_we             | cfg_wdata (capacity_in_use)
//
// An accepted item is latched, every cell then compares its key, and the
// chain then shifts; the result strobe is registered from the shift state.
// A new item can be accepted in the shift state; busy is high only during the
// compare cycle, which the single key match latch in each cell sets.
// Reset clears the valid bits, occupancy, capacity (to 16) and control; the
// store starts empty with no clearing pass. The receiver cannot stall.
`default_nettype none

module lru_key_value_cache_core
	import lkv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic signed [KEY_W-1:0]  key,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	output logic                   done,
	output logic                   found,
	output logic signed [DATA_W-1:0] read_value,
	output logic                   evicted,
	output logic signed [KEY_W-1:0]  evicted_key
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t              state_q;
	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   value_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    occ_q;
	logic                done_q;
	logic                found_q;
	logic [DATA_W-1:0]   read_value_q;
	logic                evicted_q;
	logic [KEY_W-1:0]    evicted_key_q;

	logic                accept;
	lkv_bcast_t          bc;
	logic [ENTRIES-1:0]  valid_vec;
	logic [ENTRIES-1:0]  match_vec;
	logic [ENTRIES-1:0]  shift_vec;
	logic [KEY_W-1:0]    cell_key  [ENTRIES];
	logic [DATA_W-1:0]   cell_data [ENTRIES];

	logic                hit;
	logic [IDX_W-1:0]    hit_idx;
	logic [DATA_W-1:0]   hit_data;
	logic [KEY_W-1:0]    tail_key;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    eff_cap;
	logic                full;
	logic                do_insert;
	logic                do_evict;
	logic [DATA_W-1:0]   front_data;

	assign busy   = (state_q == ST_CMP);
	assign accept = start && !busy;

	assign bc.cmp = (state_q == ST_CMP);
	assign bc.upd = (state_q == ST_UPD);
	assign bc.key = key_q;

	// cell chain: cell 0 is the most recent entry
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_front
			lkv_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.bc         (bc),
				.shift      (shift_vec[i]),
				.prev_valid (1'b1),
				.prev_key   (key_q),
				.prev_data  (front_data),
				.valid      (valid_vec[i]),
				.key        (cell_key[i]),
				.data       (cell_data[i]),
				.match      (match_vec[i])
			);
		end else begin : g_body
			lkv_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.bc         (bc),
				.shift      (shift_vec[i]),
				.prev_valid (valid_vec[i-1]),
				.prev_key   (cell_key[i-1]),
				.prev_data  (cell_data[i-1]),
				.valid      (valid_vec[i]),
				.key        (cell_key[i]),
				.data       (cell_data[i]),
				.match      (match_vec[i])
			);
		end
	end

	// encode the one-hot match and pick out hit data and tail key
	always_comb begin
		hit_idx  = '0;
		hit_data = '0;
		tail_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_data = hit_data | cell_data[i];
			end
			if (CNT_W'(i + 1) == occ_q) begin
				tail_key = tail_key | cell_key[i];
			end
		end
	end

	assign hit = |match_vec;

	// clamp the capacity to 1 .. ENTRIES
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		eff_cap = cap_ext;
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end
	end

	assign full       = (CMP_W'(occ_q) >= eff_cap);
	assign do_insert  = (op_q == OP_PUT) && !hit;
	assign do_evict   = do_insert && full;
	assign front_data = (op_q == OP_PUT) ? value_q : hit_data;

	// select the cells that take their neighbor's contents
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit) begin
				shift_vec[i] = (IDX_W'(i) <= hit_idx);
			end else if (do_evict) begin
				shift_vec[i] = (CNT_W'(i) < occ_q);
			end else begin
				shift_vec[i] = do_insert && (CNT_W'(i) <= occ_q);
			end
		end
	end

	// sequence, capacity register, occupancy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			done_q <= (state_q == ST_UPD);
			if ((state_q == ST_UPD) && do_insert && !do_evict) begin
				occ_q <= occ_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= accept ? ST_CMP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			key_q   <= key;
			value_q <= value;
		end
	end

	// register the result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			found_q       <= hit;
			read_value_q  <= (hit && (op_q == OP_GET)) ? hit_data : '0;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? tail_key : '0;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// keys are unique among valid cells
	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $onehot0(match_vec))
		else $error("more than one cell matched the key");

	// valid cells form a prefix whose length is the occupancy
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ_q))
		else $error("occupancy disagrees with valid cells");

	// a strobe follows an update cycle only
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_UPD))
		else $error("result strobe without an update");

	// an eviction never accompanies a hit
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && evicted_q) |-> !found_q)
		else $error("eviction reported on a hit");

endmodule

`default_nettype wire

// ----- test/lru_key_value_cache_core_tb.sv -----
// lru_key_value_cache_core_tb: self-checking bench for the LRU key-value cache
// core, driving get/put items and capacity writes against a shadow cache model.
// Depends on lkv_pkg and lru_key_value_cache_core.
`default_nettype none

module lru_key_value_cache_core_tb;
	import lkv_pkg::*;

	localparam int ENTRIES = 16;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 55;
	localparam int SETTLE = 4;
	localparam int TAIL_CYCLES = 8;

	// one queued action: a command item or a capacity write
	typedef struct {
		logic                     is_cfg;
		logic [CAP_W-1:0]         cap;
		logic                     op;
		logic [KEY_W-1:0]         k;
		logic [DATA_W-1:0]        v;
		int                       gap;
	} cache_cmd_t;

	typedef struct packed {
		logic                     found;
		logic [DATA_W-1:0]        read_value;
		logic                     evicted;
		logic [KEY_W-1:0]         evicted_key;
	} cache_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic operation = OP_GET;
	logic signed [KEY_W-1:0] key = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic done;
	logic found;
	logic signed [DATA_W-1:0] read_value;
	logic evicted;
	logic signed [KEY_W-1:0] evicted_key;

	// shadow copy of the cache contents and capacity register
	logic             sh_valid [ENTRIES];
	logic [KEY_W-1:0] sh_key   [ENTRIES];
	logic [DATA_W-1:0] sh_data [ENTRIES];
	logic [3:0]       sh_rank  [ENTRIES];
	int               sh_count = 0;
	logic [CAP_W-1:0] sh_cap = CAP_RESET;

	cache_cmd_t pending_cmds [$];
	cache_reply_t expected_replies [$];
	logic [KEY_W-1:0] key_pool [$];

	int in_flight = 0;
	int gap_left = 0;
	logic gap_armed = 1'b0;
	int quiet = 0;
	logic burst_phase = 1'b0;
	int errors = 0;
	int items_done = 0;
	int hits = 0;
	int evictions = 0;
	int cap_writes = 0;

	lru_key_value_cache_core #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.found      (found),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

	always #1 clk = ~clk;

	// Apply one get or put to the shadow cache and return the result it gives.
	function automatic cache_reply_t shadow_access(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		cache_reply_t r;
		int hit;
		int victim;
		int slot;
		int eff_cap;
		logic [3:0] old_rank;
		r = '0;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && sh_valid[i] && sh_key[i] == k)
				hit = i;
		if (hit >= 0) begin
			r.found = 1'b1;
			if (op == OP_PUT)
				sh_data[hit] = v;
			else
				r.read_value = sh_data[hit];
			// promote the hit entry, age the ones that were more recent
			old_rank = sh_rank[hit];
			for (int j = 0; j < ENTRIES; j++)
				if (sh_valid[j] && sh_rank[j] < old_rank)
					sh_rank[j]++;
			sh_rank[hit] = '0;
		end else if (op == OP_PUT) begin
			eff_cap = (sh_cap == 0) ? 1 : ((sh_cap > ENTRIES) ? ENTRIES : int'(sh_cap));
			// drop the least recent entry when full
			if (sh_count >= eff_cap && sh_count > 0) begin
				victim = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (sh_valid[i] && (victim < 0 || sh_rank[i] > sh_rank[victim]))
						victim = i;
				r.evicted = 1'b1;
				r.evicted_key = sh_key[victim];
				sh_valid[victim] = 1'b0;
				sh_count--;
			end
			slot = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !sh_valid[i])
					slot = i;
			if (slot >= 0) begin
				for (int j = 0; j < ENTRIES; j++)
					if (sh_valid[j])
						sh_rank[j]++;
				sh_valid[slot] = 1'b1;
				sh_key[slot] = k;
				sh_data[slot] = v;
				sh_rank[slot] = '0;
				sh_count++;
			end
		end
		return r;
	endfunction

	task automatic queue_item(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		cache_cmd_t c;
		c.is_cfg = 1'b0;
		c.cap = '0;
		c.op = op;
		c.k = k;
		c.v = v;
		c.gap = burst_phase ? 0 : $urandom_range(0, 16);
		pending_cmds.push_back(c);
	endtask

	task automatic queue_cap(input logic [CAP_W-1:0] cap);
		cache_cmd_t c;
		c.is_cfg = 1'b1;
		c.cap = cap;
		c.op = OP_GET;
		c.k = '0;
		c.v = '0;
		c.gap = 0;
		pending_cmds.push_back(c);
	endtask

	// Driver: present items from the pending queue, write capacity when idle.
	always @(posedge clk or negedge arst_n) begin
		cache_cmd_t head;
		logic nxt_start;
		logic nxt_cfg_we;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			in_flight = 0;
			gap_left = 0;
			gap_armed = 1'b0;
			quiet = 0;
			sh_count = 0;
			sh_cap = CAP_RESET;
			for (int i = 0; i < ENTRIES; i++) begin
				sh_valid[i] = 1'b0;
				sh_rank[i] = '0;
			end
		end else begin
			nxt_start = start;
			nxt_cfg_we = 1'b0;
			if (done)
				in_flight--;
			// retire the item on the bus once the block takes it
			if (start && !busy) begin
				head = pending_cmds.pop_front();
				expected_replies.push_back(shadow_access(head.op, head.k, head.v));
				in_flight++;
				nxt_start = 1'b0;
			end
			if (!nxt_start && pending_cmds.size() != 0) begin
				head = pending_cmds[0];
				if (head.is_cfg) begin
					// hold the write until the block has drained and settled
					if (in_flight == 0) begin
						if (quiet < SETTLE) begin
							quiet++;
						end else begin
							nxt_cfg_we = 1'b1;
							cfg_wdata <= head.cap;
							sh_cap = head.cap;
							void'(pending_cmds.pop_front());
							quiet = 0;
							cap_writes++;
						end
					end else begin
						quiet = 0;
					end
				end else begin
					if (!gap_armed) begin
						gap_left = head.gap;
						gap_armed = 1'b1;
					end
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						nxt_start = 1'b1;
						operation <= head.op;
						key <= head.k;
						value <= head.v;
						gap_armed = 1'b0;
					end
				end
			end
			start <= nxt_start;
			cfg_we <= nxt_cfg_we;
		end
	end

	// Monitor: compare every result strobe with the oldest expectation.
	always @(posedge clk) begin
		cache_reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: result with nothing expected: found %b read_value %h evicted %b key %h",
					$time, found, read_value, evicted, evicted_key);
				errors++;
			end else begin
				want = expected_replies.pop_front();
				items_done++;
				if (want.found)
					hits++;
				if (want.evicted)
					evictions++;
				if (found !== want.found) begin
					$display("%0t: found expected %b got %b", $time, want.found, found);
					errors++;
				end
				if (read_value !== want.read_value) begin
					$display("%0t: read_value expected %h got %h", $time, want.read_value,
						read_value);
					errors++;
				end
				if (evicted !== want.evicted) begin
					$display("%0t: evicted expected %b got %b", $time, want.evicted, evicted);
					errors++;
				end
				if (evicted_key !== want.evicted_key) begin
					$display("%0t: evicted_key expected %h got %h", $time, want.evicted_key,
						evicted_key);
					errors++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [CAP_W-1:0] cap;
		logic [KEY_W-1:0] k;
		int pool_size;

		// directed: empty store, extreme keys and values, update, lookups, evictions
		burst_phase = 1'b0;
		queue_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
		queue_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_item(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_item(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		queue_item(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_item(OP_PUT, 32'h0000_0000, 32'd123);
		queue_item(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
		queue_item(OP_GET, 32'd5, 32'hDEAD_BEEF);
		queue_item(OP_PUT, 32'd5, 32'd55);
		// shrink capacity below occupancy: each put miss evicts exactly one
		queue_cap(5'd2);
		queue_item(OP_PUT, 32'd6, 32'd66);
		queue_item(OP_PUT, 32'd7, 32'd77);
		queue_item(OP_GET, 32'hFFFF_FFFF, 32'd0);
		queue_item(OP_GET, 32'd7, 32'd0);
		// zero capacity behaves as one
		queue_cap(5'd0);
		queue_item(OP_PUT, 32'd9, 32'd99);
		queue_item(OP_PUT, 32'd10, 32'd100);
		queue_item(OP_GET, 32'd9, 32'd0);
		queue_item(OP_GET, 32'd10, 32'd0);

		// random phases, each with its own capacity, key pool and idling style
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = 5'd31;
				1: cap = 5'd16;
				2: cap = 5'd1;
				3: cap = 5'd0;
				4: cap = 5'd17;
				5: cap = 5'd3;
				6: cap = 5'd8;
				default: cap = CAP_W'($urandom_range(0, 31));
			endcase
			queue_cap(cap);
			burst_phase = ($urandom_range(0, 3) == 0);
			pool_size = $urandom_range(2, 28);
			key_pool.delete();
			for (int i = 0; i < pool_size; i++) begin
				case ($urandom_range(0, 11))
					0: k = 32'h8000_0000;
					1: k = 32'h7FFF_FFFF;
					2: k = 32'hFFFF_FFFF;
					3: k = 32'h0000_0000;
					default: k = $urandom;
				endcase
				key_pool.push_back(k);
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_size - 1)];
				else
					k = $urandom;
				queue_item(1'($urandom_range(0, 1)), k, $urandom);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || in_flight != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (expected_replies.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_replies.size());
			errors++;
		end
		$display("Checked %0d get/put results over %0d capacity settings, %0d hits, %0d evictions.",
			items_done, cap_writes + 1, hits, evictions);
		if (errors == 0)
			$display("lru_key_value_cache_core_tb OK");
		else
			$display("lru_key_value_cache_core_tb NOT OK");
		$finish;
	end

	// Abort a hung run.
	initial begin
		#400000;
		$display("lru_key_value_cache_core_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_core.sv
test/lru_key_value_cache_core_tb.sv
